// ----- rtl/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch operand, restart pointer
    logic append;   // write at tail, bump count
    logic clear;    // drop count to zero
    logic rd;       // read entry at pointer, advance pointer
    logic wr_back;  // write read data one place below its source
    logic found;    // record match position
    logic dec;      // count minus one
    logic emit;     // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;     // count at capacity
    logic at_end;   // pointer reached count
    logic chk;      // read data valid this cycle
    logic match;    // read data equals operand
  } status_t;

endpackage

// ----- rtl/ole_req_if.sv -----
// ----------------------------------------------------------------------------
// ole_req_if
// Request channel: operation code and operand word.
// ----------------------------------------------------------------------------
interface ole_req_if;
  logic                                valid;
  logic                                ready;
  logic [ole_pkg::FUNC_W-1:0]          func;
  logic signed [ole_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

// ----- rtl/ole_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ole_rsp_if
// Response channel: status, position and resulting entry count.
// ----------------------------------------------------------------------------
interface ole_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [ole_pkg::POS_W-1:0]  position;
  logic [ole_pkg::CNT_W-1:0]  count_after;

  modport source (output valid, output ok, output position, output count_after,
                  input ready);
  modport sink   (input valid, input ok, input position, input count_after,
                  output ready);
endinterface

// ----- rtl/ole_datapath.sv -----
// ----------------------------------------------------------------------------
// ole_datapath
// Entry memory, count, scan pointer, compare and result register.
// ----------------------------------------------------------------------------
module ole_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ole_pkg::cmd_t                       cmd_i,
  output ole_pkg::status_t                    stat_o,
  input  logic signed [ole_pkg::VALUE_W-1:0]  req_value_i,
  output logic                                rsp_ok_o,
  output logic [ole_pkg::POS_W-1:0]           rsp_position_o,
  output logic [ole_pkg::CNT_W-1:0]           rsp_count_after_o
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [ole_pkg::VALUE_W-1:0] mem [CAPACITY];

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             chk_q, chk_d;
  logic signed [ole_pkg::VALUE_W-1:0] value_q, value_d;
  logic signed [ole_pkg::VALUE_W-1:0] rd_data_q;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             ok_q, ok_d;

  logic                               mem_we;
  logic [IDX_W-1:0]                   mem_waddr;
  logic signed [ole_pkg::VALUE_W-1:0] mem_wdata;
  logic [CW-1:0]                      idx_m1;
  logic [CW-1:0]                      idx_m2;

  logic                         rsp_ok_q;
  logic [ole_pkg::POS_W-1:0]    rsp_pos_q;
  logic [ole_pkg::CNT_W-1:0]    rsp_cnt_q;

  assign idx_m1 = idx_q - CW'(1);
  assign idx_m2 = idx_q - CW'(2);

  always_comb begin
    stat_o.full   = (count_q == CW'(CAPACITY));
    stat_o.at_end = (idx_q == count_q);
    stat_o.chk    = chk_q;
    stat_o.match  = (rd_data_q == value_q);
  end

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    chk_d   = cmd_i.rd;
    value_d = value_q;
    pos_d   = pos_q;
    ok_d    = ok_q;
    if (cmd_i.load) begin
      value_d = req_value_i;
      idx_d   = '0;
      pos_d   = '0;
      ok_d    = 1'b0;
    end
    if (cmd_i.append) begin
      pos_d   = count_q[IDX_W-1:0];
      count_d = count_q + CW'(1);
      ok_d    = 1'b1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      ok_d    = 1'b1;
    end
    if (cmd_i.rd) begin
      idx_d = idx_q + CW'(1);
    end
    if (cmd_i.found) begin
      pos_d = idx_m1[IDX_W-1:0];
      ok_d  = 1'b1;
    end
    if (cmd_i.dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // memory write: tail append or shift-down copy
  always_comb begin
    mem_we    = cmd_i.append | cmd_i.wr_back;
    mem_waddr = cmd_i.append ? count_q[IDX_W-1:0] : idx_m2[IDX_W-1:0];
    mem_wdata = cmd_i.append ? value_q : rd_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      chk_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
    ok_q    <= ok_d;
    if (cmd_i.emit) begin
      rsp_ok_q  <= ok_q;
      rsp_pos_q <= ole_pkg::POS_W'(pos_q);
      rsp_cnt_q <= ole_pkg::CNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[idx_q[IDX_W-1:0]];
    end
  end

  assign rsp_ok_o          = rsp_ok_q;
  assign rsp_position_o    = rsp_pos_q;
  assign rsp_count_after_o = rsp_cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_dec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dec |-> count_q != '0)
    else $error("count decrement on empty list");

  a_wb_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_back |-> chk_q && idx_q >= CW'(2))
    else $error("shift write without fresh read data");

endmodule

// ----- rtl/ole_ctrl.sv -----
// ----------------------------------------------------------------------------
// ole_ctrl
// Sequencer: dispatches the operation, runs scan and shift, hands off result.
// ----------------------------------------------------------------------------
module ole_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [ole_pkg::FUNC_W-1:0]  req_func_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  input  ole_pkg::status_t            stat_i,
  output ole_pkg::cmd_t               cmd_o
);

  ole_pkg::state_e state_q, state_d;
  ole_pkg::func_e  op_q, op_d;
  logic            rsp_valid_q, rsp_valid_d;
  logic            hit;
  logic            out_free;

  assign hit      = stat_i.chk & stat_i.match;
  assign out_free = !rsp_valid_q || rsp_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ole_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          op_d    = ole_pkg::func_e'(req_func_i);
          state_d = ole_pkg::ST_EXEC;
        end
      end
      ole_pkg::ST_EXEC: begin
        if (op_q == ole_pkg::FUNC_REMOVE || op_q == ole_pkg::FUNC_SEARCH) begin
          state_d = ole_pkg::ST_SCAN;
        end else begin
          state_d = ole_pkg::ST_DONE;
        end
      end
      ole_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = (op_q == ole_pkg::FUNC_REMOVE) ? ole_pkg::ST_SHIFT
                                                   : ole_pkg::ST_DONE;
        end else if (stat_i.at_end) begin
          state_d = ole_pkg::ST_DONE;
        end
      end
      ole_pkg::ST_SHIFT: begin
        if (stat_i.at_end && !stat_i.chk) begin
          state_d = ole_pkg::ST_DONE;
        end
      end
      ole_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ole_pkg::ST_IDLE;
        end
      end
      default: state_d = ole_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ole_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ole_pkg::ST_EXEC: begin
        case (op_q)
          ole_pkg::FUNC_APPEND: cmd_o.append = !stat_i.full;
          ole_pkg::FUNC_CLEAR:  cmd_o.clear  = 1'b1;
          default:              cmd_o        = '0;
        endcase
      end
      ole_pkg::ST_SCAN: begin
        cmd_o.found = hit;
        cmd_o.rd    = !hit && !stat_i.at_end;
      end
      ole_pkg::ST_SHIFT: begin
        cmd_o.rd      = !stat_i.at_end;
        cmd_o.wr_back = stat_i.chk;
        cmd_o.dec     = stat_i.at_end && !stat_i.chk;
      end
      ole_pkg::ST_DONE: begin
        cmd_o.emit = out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ole_pkg::ST_IDLE;
      op_q        <= ole_pkg::FUNC_APPEND;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.append |-> !stat_i.full)
    else $error("append issued on full list");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result register overwritten while pending");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |-> !stat_i.at_end)
    else $error("read past last entry");

  a_found_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.found |=> (state_q == ole_pkg::ST_SHIFT || state_q == ole_pkg::ST_DONE))
    else $error("match not followed by shift or result");

endmodule

// ----- rtl/ordered_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded ordered list of signed words: append, remove, search, clear.
// ----------------------------------------------------------------------------
// Flow (accept to result valid): append/clear pass EXEC straight to DONE;
//   search reads entries up to the hit (all of them on a miss), in order.
// Remove then copies every entry after the match one place down, none when
//   the match is the last entry. Scan and shift are paced by the single memory read port.
// One item in flight: the next item is taken once the result sits in the output
//   register. Async active-low reset empties the list; memory is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_engine_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ole_req_if.sink      req_i,
  ole_rsp_if.source    rsp_o
);

  // command/status bundle between sequencer and datapath
  ole_pkg::cmd_t    cmd;
  ole_pkg::status_t stat;

  logic                        ctrl_req_ready;
  logic                        ctrl_rsp_valid;
  logic                        dp_ok;
  logic [ole_pkg::POS_W-1:0]   dp_pos;
  logic [ole_pkg::CNT_W-1:0]   dp_cnt;

  // Sequencer: IDLE -> EXEC -> (SCAN -> SHIFT) -> DONE.
  // SCAN reads one entry per cycle with the compare in the cycle after the read;
  // SHIFT copies each later entry one place down, also one per cycle.
  ole_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (ctrl_req_ready),
    .req_func_i  (req_i.func),
    .rsp_valid_o (ctrl_rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: entry memory (1 write, 1 registered read), count, pointer,
  // compare and the output register that holds the pending result.
  ole_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_value_i       (req_i.value),
    .rsp_ok_o          (dp_ok),
    .rsp_position_o    (dp_pos),
    .rsp_count_after_o (dp_cnt)
  );

  assign req_i.ready       = ctrl_req_ready;
  assign rsp_o.valid       = ctrl_rsp_valid;
  assign rsp_o.ok          = dp_ok;
  assign rsp_o.position    = dp_pos;
  assign rsp_o.count_after = dp_cnt;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ordered_list_engine_top. A queue of list operations
// is driven in random bursts on the request channel; a shadow copy of the list
// predicts every response, which is checked field by field as it arrives.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned LIMIT     = 400000; // cycles, far beyond a slow run
  localparam int unsigned TAIL_WAIT = 2 * CAPACITY + 10;
  localparam int unsigned N_RANDOM  = 550;

  // Receiver stall styles, stepped through as the run goes on.
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_RANDOM,  // ready about 70% of cycles
    RX_STRIDE,  // ready one cycle in four
    RX_LONG     // ready, broken by long stalls
  } rx_mode_e;

  typedef struct packed {
    ole_pkg::func_e func;
    logic [31:0]    value;
    logic           drain;  // hold off until every response has come back
  } list_op_t;

  typedef struct packed {
    logic                      ok;
    logic [ole_pkg::POS_W-1:0] position;
    logic [ole_pkg::CNT_W-1:0] count_after;
  } list_rsp_t;

  logic clk_i;
  logic rst_ni;

  ole_req_if req_if ();
  ole_rsp_if rsp_if ();

  ordered_list_engine_top #(
    .CAPACITY (CAPACITY)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // --------------------------------------------------------------------------
  // Clock, reset, cycle count
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // --------------------------------------------------------------------------
  // Shadow list and predictor
  // --------------------------------------------------------------------------
  logic [31:0]  shadow_words [CAPACITY];
  int unsigned  shadow_len = 0;

  list_op_t     op_q[$];           // operations still to be sent
  list_rsp_t    list_result_q[$];  // predicted responses, oldest first

  int unsigned  accepted_count = 0;
  int unsigned  received_count = 0;
  int unsigned  fail_count     = 0;

  // coverage-style tallies for the summary
  int unsigned  op_seen [4];
  int unsigned  full_refused = 0;
  int unsigned  lookup_hits  = 0;
  int unsigned  lookup_miss  = 0;

  // Applies one operation to the shadow list and returns the response the
  // block must give. Equality is on all 32 bits; only live entries are read.
  function automatic list_rsp_t apply_list_op(ole_pkg::func_e f, logic [31:0] v);
    list_rsp_t r;
    int        hit;
    int        i;
    r   = '0;
    hit = -1;
    op_seen[f]++;
    if (f == ole_pkg::FUNC_REMOVE || f == ole_pkg::FUNC_SEARCH) begin
      for (i = 0; i < int'(shadow_len); i++) begin
        if (hit < 0 && shadow_words[i] == v) hit = i;
      end
      if (hit < 0) lookup_miss++;
      else lookup_hits++;
    end
    case (f)
      ole_pkg::FUNC_APPEND: begin
        if (shadow_len < CAPACITY) begin
          shadow_words[shadow_len] = v;
          r.position = shadow_len[ole_pkg::POS_W-1:0];
          shadow_len++;
          r.ok = 1'b1;
        end else begin
          full_refused++;
        end
      end
      ole_pkg::FUNC_REMOVE: begin
        if (hit >= 0) begin
          r.position = hit[ole_pkg::POS_W-1:0];
          // close the gap, later entries keep their order
          for (i = hit; i + 1 < int'(shadow_len); i++) shadow_words[i] = shadow_words[i + 1];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      ole_pkg::FUNC_SEARCH: begin
        if (hit >= 0) begin
          r.position = hit[ole_pkg::POS_W-1:0];
          r.ok       = 1'b1;
        end
      end
      default: begin
        // clear only drops the count; stale words stay but are never read
        shadow_len = 0;
        r.ok       = 1'b1;
      end
    endcase
    r.count_after = shadow_len[ole_pkg::CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("response %0d %s: got %0h, want %0h",
                                received_count, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps. An op marked
  // drain waits until all outstanding responses have been checked.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : op_driver
    bit          hold;
    bit          fire;
    int unsigned pick;
    if (rst_ni) begin
      hold = req_if.valid && !req_if.ready;
      fire = req_if.valid && req_if.ready;
      if (fire) begin
        list_result_q.push_back(apply_list_op(ole_pkg::func_e'(req_if.func),
                                              req_if.value));
        accepted_count <= accepted_count + 1;
        op_q.delete(0);
      end
      // a presented item stays put until the block takes it
      if (!hold) begin
        if (op_q.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (op_q[0].drain && (fire || accepted_count != received_count)) begin
          req_if.valid <= 1'b0;
        end else begin
          req_if.valid <= 1'b1;
          req_if.func  <= op_q[0].func;
          req_if.value <= op_q[0].value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            pick       = $urandom_range(0, 9);
            // short gaps land inside a scan, long ones span whole ops
            if (pick < 4)      gap_left = 0;
            else if (pick < 8) gap_left = $urandom_range(1, 5);
            else               gap_left = $urandom_range(10, 45);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor and receiver stall pattern
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin : rsp_monitor
    list_rsp_t want;
    logic      rdy;
    rx_mode_e  mode;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        received_count <= received_count + 1;
        if (list_result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected response ok=%0b pos=%0d cnt=%0d",
                                    rsp_if.ok, rsp_if.position, rsp_if.count_after));
        end else begin
          want = list_result_q.pop_front();
          check_field("ok",          32'(rsp_if.ok),          32'(want.ok));
          check_field("position",    32'(rsp_if.position),    32'(want.position));
          check_field("count_after", 32'(rsp_if.count_after), 32'(want.count_after));
        end
      end
      mode = rx_mode_e'(2'((cycle_count / 300) % 4));
      case (mode)
        RX_OPEN:   rdy = 1'b1;
        RX_RANDOM: rdy = ($urandom_range(0, 9) < 7);
        RX_STRIDE: rdy = (cycle_count % 4 == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 30);
          end
        end
      endcase
      rsp_if.ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_item(ole_pkg::func_e f, logic [31:0] v, logic drain = 1'b0);
    list_op_t op;
    op.func  = f;
    op.value = v;
    op.drain = drain;
    op_q.push_back(op);
  endtask

  initial begin : stimulus
    logic [31:0] fill_words [CAPACITY];
    logic [31:0] pool [6];
    int unsigned append_w;
    int unsigned r;
    logic [31:0] v;

    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.func  = ole_pkg::FUNC_APPEND;
    req_if.value = '0;
    rsp_if.ready = 1'b0;

    // Directed: empty-list cases, both 32-bit extremes, a duplicate, fill to
    // capacity, append on full, hit at the last slot, one-bit-off miss, remove
    // of first duplicate / tail / head, and a clear that leaves stale words.
    add_item(ole_pkg::FUNC_CLEAR,  32'h0);
    add_item(ole_pkg::FUNC_SEARCH, 32'h5);
    add_item(ole_pkg::FUNC_REMOVE, 32'h5);
    fill_words[0] = 32'h8000_0000;
    fill_words[1] = 32'h7fff_ffff;
    fill_words[2] = 32'h0000_0000;
    fill_words[3] = 32'hffff_ffff;
    fill_words[4] = 32'h7fff_ffff;
    for (int i = 5; i < CAPACITY; i++) fill_words[i] = $urandom;
    for (int i = 0; i < CAPACITY; i++) add_item(ole_pkg::FUNC_APPEND, fill_words[i]);
    add_item(ole_pkg::FUNC_APPEND, 32'h1);
    add_item(ole_pkg::FUNC_SEARCH, fill_words[CAPACITY-1]);
    add_item(ole_pkg::FUNC_SEARCH, 32'h7fff_fffe);
    add_item(ole_pkg::FUNC_REMOVE, 32'h7fff_ffff);
    add_item(ole_pkg::FUNC_REMOVE, fill_words[CAPACITY-1]);
    add_item(ole_pkg::FUNC_REMOVE, 32'h8000_0000);
    add_item(ole_pkg::FUNC_CLEAR,  32'hffff_ffff);
    add_item(ole_pkg::FUNC_SEARCH, 32'h0);

    // Random: values mostly from a small pool so removes and searches hit;
    // the append weight shifts every 50 ops to sweep fill levels.
    append_w = 45;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       append_w = 25;
          1:       append_w = 45;
          default: append_w = 70;
        endcase
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7fff_ffff;
        pool[2] = 32'h0000_0000;
        pool[3] = $urandom;
        pool[4] = pool[3] ^ (32'h1 << $urandom_range(0, 31));  // near miss
        pool[5] = 32'hffff_ffff;
      end
      v = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 5)] : $urandom;
      r = $urandom_range(0, 99);
      if (r < 3)                 add_item(ole_pkg::FUNC_CLEAR, v, n == 0);
      else if (r < 3 + append_w) add_item(ole_pkg::FUNC_APPEND, v, n == 0 || n % 137 == 0);
      else if (r % 2 == 0)       add_item(ole_pkg::FUNC_REMOVE, v, n == 0);
      else                       add_item(ole_pkg::FUNC_SEARCH, v, n == 0);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything sent and answered, then let any stray response show up
    while (op_q.size() != 0 || accepted_count != received_count) @(negedge clk_i);
    repeat (TAIL_WAIT) @(negedge clk_i);

    if (list_result_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", list_result_q.size()));

    $display("Ran %0d ops: append %0d, remove %0d, search %0d, clear %0d.",
             accepted_count, op_seen[ole_pkg::FUNC_APPEND],
             op_seen[ole_pkg::FUNC_REMOVE], op_seen[ole_pkg::FUNC_SEARCH],
             op_seen[ole_pkg::FUNC_CLEAR]);
    $display("Lookups hit %0d, missed %0d; appends refused on full list %0d.",
             lookup_hits, lookup_miss, full_refused);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ole_pkg.sv
rtl/ole_req_if.sv
rtl/ole_rsp_if.sv
rtl/ole_datapath.sv
rtl/ole_ctrl.sv
rtl/ordered_list_engine_top.sv
sim/testbench.sv
